// File: sv/adaptive_traffic_light_controller_assert.svh
// Assertion macros for the traffic light controller checker.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef ADAPTIVE_TRAFFIC_LIGHT_CONTROLLER_ASSERT_SVH
`define ADAPTIVE_TRAFFIC_LIGHT_CONTROLLER_ASSERT_SVH

// Same-cycle implication, off while reset is held
`define ATLC_CHECK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held
`define ATLC_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Condition that must hold in the cycle after a reset edge
`define ATLC_CHECK_RESET(lbl, cons, msg) \
    lbl: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) \
        else $error(msg);

`endif

// File: sv/atlc_pkg.sv
// Shared types, constants and helper functions of the traffic light controller.
// No dependencies; every other file but the assertion header refers to it by scoped names.
package atlc_pkg;

    // Sizing
    localparam int CAR_COUNT_BITS = 16;
    localparam int MS_COUNT_BITS  = 17;
    localparam int YR_W           = 14;
    localparam int GREEN_W        = 17;
    localparam int THR_W          = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 17;
    localparam int SUBSEC_W       = 10;
    localparam int SEC_W          = 8;
    localparam int CARS_OUT_W     = 16;
    localparam int LOAD_W         = 18;
    localparam int CMP_W          = ((CAR_COUNT_BITS > THR_W) ? CAR_COUNT_BITS : THR_W) + 1;

    // Milliseconds to seconds: multiply by ceil(2^28/1000), exact for all 18-bit inputs
    localparam int          SEC_SHIFT = 28;
    localparam int          RECIP_W   = 19;
    localparam int          PROD_W    = LOAD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] SEC_RECIP = 19'd268436;

    localparam logic [SUBSEC_W-1:0] MS_PER_SECOND = 10'd1000;
    localparam logic [1:0]          STREAK_NEEDED = 2'd2;
    localparam logic [1:0]          STREAK_MAX    = 2'd3;

    // Register defaults
    localparam logic [YR_W-1:0]    YELLOW_RED_RST  = 14'd3000;
    localparam logic [GREEN_W-1:0] GREEN_BASE_RST  = 17'd60000;
    localparam logic [GREEN_W-1:0] GREEN_LONG_RST  = 17'd75000;
    localparam logic [GREEN_W-1:0] GREEN_SHORT_RST = 17'd45000;
    localparam logic [GREEN_W-1:0] GREEN_MAX_RST   = 17'd90000;
    localparam logic [GREEN_W-1:0] GREEN_MIN_RST   = 17'd30000;
    localparam logic [THR_W-1:0]   THRESHOLD_RST   = 16'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_YELLOW_RED  = 3'd0,
        CFG_GREEN_BASE  = 3'd1,
        CFG_GREEN_LONG  = 3'd2,
        CFG_GREEN_SHORT = 3'd3,
        CFG_GREEN_MAX   = 3'd4,
        CFG_GREEN_MIN   = 3'd5,
        CFG_THRESHOLD   = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_RED1      = 3'd0,
        PH_EW_GREEN  = 3'd1,
        PH_EW_YELLOW = 3'd2,
        PH_RED2      = 3'd3,
        PH_NS_GREEN  = 3'd4,
        PH_NS_YELLOW = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        TIER_BASE = 3'd0,
        TIER_EW75 = 3'd1,
        TIER_EW90 = 3'd2,
        TIER_NS75 = 3'd3,
        TIER_NS90 = 3'd4
    } t_tier;

    typedef enum logic [1:0] {
        LAMP_RED    = 2'd0,
        LAMP_YELLOW = 2'd1,
        LAMP_GREEN  = 2'd2
    } t_lamp;

    typedef struct packed {
        logic [YR_W-1:0]    yellow_red_ms;
        logic [GREEN_W-1:0] green_base_ms;
        logic [GREEN_W-1:0] green_long_ms;
        logic [GREEN_W-1:0] green_short_ms;
        logic [GREEN_W-1:0] green_max_ms;
        logic [GREEN_W-1:0] green_min_ms;
        logic [THR_W-1:0]   imbalance_threshold;
    } t_cfg;

    typedef struct packed {
        t_tier      tier;
        logic [1:0] ew_streak;
        logic [1:0] ns_streak;
    } t_tier_st;

    typedef struct packed {
        logic ms_tick;
        logic ew_car;
        logic ns_car;
    } t_in_word;

    typedef struct packed {
        logic [1:0]            ew_light;
        logic [1:0]            ns_light;
        logic [2:0]            phase_now;
        logic [2:0]            tier_now;
        logic [SEC_W-1:0]      ew_seconds_left;
        logic [SEC_W-1:0]      ns_seconds_left;
        logic [CARS_OUT_W-1:0] ew_cars_seen;
        logic [CARS_OUT_W-1:0] ns_cars_seen;
    } t_out_word;

    // Green time of the east-west direction for a tier
    function automatic logic [GREEN_W-1:0] green_ew(t_tier tier, t_cfg cfg);
        case (tier)
            TIER_EW75: return cfg.green_long_ms;
            TIER_EW90: return cfg.green_max_ms;
            TIER_NS75: return cfg.green_short_ms;
            TIER_NS90: return cfg.green_min_ms;
            default:   return cfg.green_base_ms;
        endcase
    endfunction

    // Green time of the north-south direction for a tier
    function automatic logic [GREEN_W-1:0] green_ns(t_tier tier, t_cfg cfg);
        case (tier)
            TIER_EW75: return cfg.green_short_ms;
            TIER_EW90: return cfg.green_min_ms;
            TIER_NS75: return cfg.green_long_ms;
            TIER_NS90: return cfg.green_max_ms;
            default:   return cfg.green_base_ms;
        endcase
    endfunction

    // Length of the given phase in milliseconds
    function automatic logic [GREEN_W-1:0] phase_dur(t_phase ph, t_tier tier, t_cfg cfg);
        case (ph)
            PH_EW_GREEN: return green_ew(tier, cfg);
            PH_NS_GREEN: return green_ns(tier, cfg);
            default:     return GREEN_W'(cfg.yellow_red_ms);
        endcase
    endfunction

    function automatic t_phase next_phase(t_phase ph);
        case (ph)
            PH_RED1:      return PH_EW_GREEN;
            PH_EW_GREEN:  return PH_EW_YELLOW;
            PH_EW_YELLOW: return PH_RED2;
            PH_RED2:      return PH_NS_GREEN;
            PH_NS_GREEN:  return PH_NS_YELLOW;
            default:      return PH_RED1;
        endcase
    endfunction

    function automatic t_lamp ew_lamp(t_phase ph);
        case (ph)
            PH_EW_GREEN:  return LAMP_GREEN;
            PH_EW_YELLOW: return LAMP_YELLOW;
            default:      return LAMP_RED;
        endcase
    endfunction

    function automatic t_lamp ns_lamp(t_phase ph);
        case (ph)
            PH_NS_GREEN:  return LAMP_GREEN;
            PH_NS_YELLOW: return LAMP_YELLOW;
            default:      return LAMP_RED;
        endcase
    endfunction

    // Whole seconds of a millisecond value, saturating at the display maximum
    function automatic logic [SEC_W-1:0] secs(logic [LOAD_W-1:0] ms);
        logic [PROD_W-1:0]           prod;
        logic [PROD_W-SEC_SHIFT-1:0] quo;
        prod = {{RECIP_W{1'b0}}, ms} * {{LOAD_W{1'b0}}, SEC_RECIP};
        quo  = prod[PROD_W-1:SEC_SHIFT];
        if (quo > (PROD_W-SEC_SHIFT)'({SEC_W{1'b1}})) begin
            return {SEC_W{1'b1}};
        end
        return quo[SEC_W-1:0];
    endfunction

    // Car count seen on the output, zero-extended or truncated to the field width
    function automatic logic [CARS_OUT_W-1:0] cars_seen(logic [CAR_COUNT_BITS-1:0] cnt);
        logic [31:0] wide;
        wide = 32'(cnt);
        return wide[CARS_OUT_W-1:0];
    endfunction

endpackage

// File: sv/adaptive_traffic_light_controller.sv
// Adaptive traffic light controller, top level.
// Input channel: i_valid / o_ready carry one word per accepted handshake: a
//   millisecond tick flag and one pulse from each car detector.
// Output channel: o_valid / i_ready carry one result word per input word: both
//   lamps, phase, tier, the two seconds-left displays and the two car counts.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx at the
//   clock edge; indexes beyond the list are dropped. Write only while idle.
// Path: an accepted word passes the input register, then the result register.
// Throughput: one word per cycle while the receiver takes results; the whole
//   state update sits between those two registers, its longest path being tier
//   update, green select and the two ms-to-seconds multipliers.
// Reset (i_rst_n low, synchronous): both stages empty, registers at defaults,
//   phase all red, tier balanced; the displays load on the first word.
// Receiver stall: the result word holds; an empty input register takes one
//   more word, and o_ready stays low from then on until the result is taken.
// Depends on atlc_pkg, atlc_cfg, atlc_in_reg, atlc_core.
module adaptive_traffic_light_controller (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  atlc_pkg::t_in_word              i_data,
    output logic                            o_ready,
    output logic                            o_valid,
    output atlc_pkg::t_out_word             o_data,
    input  logic                            i_ready,
    input  logic                            i_cfg_we,
    input  logic [atlc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [atlc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    atlc_pkg::t_cfg     cfg;
    logic               in_valid;
    atlc_pkg::t_in_word in_data;
    logic               core_ready;

    atlc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    atlc_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_data       (i_data),
        .o_ready      (o_ready),
        .o_valid      (in_valid),
        .o_data       (in_data),
        .i_next_ready (core_ready)
    );

    atlc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (in_valid),
        .i_in_data  (in_data),
        .o_in_ready (core_ready),
        .o_valid    (o_valid),
        .o_data     (o_data),
        .i_ready    (i_ready)
    );

endmodule

// File: sv/atlc_cfg.sv
// Configuration register file of the traffic light controller.
// Depends on atlc_pkg for the register layout, indexes and defaults.
module atlc_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [atlc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [atlc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output atlc_pkg::t_cfg                   o_cfg
);

    atlc_pkg::t_cfg r_cfg;

    // Load defaults on reset, write one register per enabled cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.yellow_red_ms       <= atlc_pkg::YELLOW_RED_RST;
            r_cfg.green_base_ms       <= atlc_pkg::GREEN_BASE_RST;
            r_cfg.green_long_ms       <= atlc_pkg::GREEN_LONG_RST;
            r_cfg.green_short_ms      <= atlc_pkg::GREEN_SHORT_RST;
            r_cfg.green_max_ms        <= atlc_pkg::GREEN_MAX_RST;
            r_cfg.green_min_ms        <= atlc_pkg::GREEN_MIN_RST;
            r_cfg.imbalance_threshold <= atlc_pkg::THRESHOLD_RST;
        end else if (i_cfg_we) begin
            case (atlc_pkg::t_cfg_idx'(i_cfg_idx))
                atlc_pkg::CFG_YELLOW_RED:
                    r_cfg.yellow_red_ms <= i_cfg_data[atlc_pkg::YR_W-1:0];
                atlc_pkg::CFG_GREEN_BASE:  r_cfg.green_base_ms  <= i_cfg_data;
                atlc_pkg::CFG_GREEN_LONG:  r_cfg.green_long_ms  <= i_cfg_data;
                atlc_pkg::CFG_GREEN_SHORT: r_cfg.green_short_ms <= i_cfg_data;
                atlc_pkg::CFG_GREEN_MAX:   r_cfg.green_max_ms   <= i_cfg_data;
                atlc_pkg::CFG_GREEN_MIN:   r_cfg.green_min_ms   <= i_cfg_data;
                atlc_pkg::CFG_THRESHOLD:
                    r_cfg.imbalance_threshold <= i_cfg_data[atlc_pkg::THR_W-1:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: sv/atlc_in_reg.sv
// Input register stage: captures one input word per accepted handshake.
// Depends on atlc_pkg for the input word type.
module atlc_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  atlc_pkg::t_in_word i_data,
    output logic               o_ready,
    output logic               o_valid,
    output atlc_pkg::t_in_word o_data,
    input  logic               i_next_ready
);

    logic               r_valid;
    atlc_pkg::t_in_word r_data;

    // Room when empty or when the held word moves on this cycle
    assign o_ready = !r_valid || i_next_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Capture the word on acceptance
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: sv/atlc_tier.sv
// Tier and streak update applied when the north-south yellow phase ends.
// Depends on atlc_pkg for the tier enum and tier state struct.
module atlc_tier (
    input  logic [atlc_pkg::CAR_COUNT_BITS-1:0] i_ew_count,
    input  logic [atlc_pkg::CAR_COUNT_BITS-1:0] i_ns_count,
    input  logic [atlc_pkg::THR_W-1:0]          i_threshold,
    input  atlc_pkg::t_tier_st                  i_cur,
    output atlc_pkg::t_tier_st                  o_next
);

    logic [atlc_pkg::CMP_W-1:0] ew_ext;
    logic [atlc_pkg::CMP_W-1:0] ns_ext;
    logic [atlc_pkg::CMP_W-1:0] thr_ext;
    logic                       ew_heavy;
    logic                       ns_heavy;
    logic [1:0]                 ew_inc;
    logic [1:0]                 ns_inc;

    // Compare each count against the other plus the threshold
    assign ew_ext   = atlc_pkg::CMP_W'(i_ew_count);
    assign ns_ext   = atlc_pkg::CMP_W'(i_ns_count);
    assign thr_ext  = atlc_pkg::CMP_W'(i_threshold);
    assign ew_heavy = ew_ext > (ns_ext + thr_ext);
    assign ns_heavy = ns_ext > (ew_ext + thr_ext);

    // Saturating streak increments
    assign ew_inc = (i_cur.ew_streak < atlc_pkg::STREAK_MAX) ? i_cur.ew_streak + 2'd1
                                                              : i_cur.ew_streak;
    assign ns_inc = (i_cur.ns_streak < atlc_pkg::STREAK_MAX) ? i_cur.ns_streak + 2'd1
                                                              : i_cur.ns_streak;

    // Move tier at most one step toward the heavier direction, or back toward base
    always_comb begin
        o_next = i_cur;
        if (ew_heavy) begin
            o_next.ns_streak = 2'd0;
            case (i_cur.tier)
                atlc_pkg::TIER_BASE: begin
                    o_next.tier      = atlc_pkg::TIER_EW75;
                    o_next.ew_streak = 2'd1;
                end
                atlc_pkg::TIER_EW75: begin
                    o_next.ew_streak = ew_inc;
                    if (ew_inc >= atlc_pkg::STREAK_NEEDED) begin
                        o_next.tier = atlc_pkg::TIER_EW90;
                    end
                end
                atlc_pkg::TIER_NS90: o_next.tier = atlc_pkg::TIER_NS75;
                atlc_pkg::TIER_NS75: o_next.tier = atlc_pkg::TIER_BASE;
                default: begin
                    // hold EW90
                end
            endcase
        end else if (ns_heavy) begin
            o_next.ew_streak = 2'd0;
            case (i_cur.tier)
                atlc_pkg::TIER_BASE: begin
                    o_next.tier      = atlc_pkg::TIER_NS75;
                    o_next.ns_streak = 2'd1;
                end
                atlc_pkg::TIER_NS75: begin
                    o_next.ns_streak = ns_inc;
                    if (ns_inc >= atlc_pkg::STREAK_NEEDED) begin
                        o_next.tier = atlc_pkg::TIER_NS90;
                    end
                end
                atlc_pkg::TIER_EW90: o_next.tier = atlc_pkg::TIER_EW75;
                atlc_pkg::TIER_EW75: o_next.tier = atlc_pkg::TIER_BASE;
                default: begin
                    // hold NS90
                end
            endcase
        end else begin
            o_next.ew_streak = 2'd0;
            o_next.ns_streak = 2'd0;
            case (i_cur.tier)
                atlc_pkg::TIER_EW90: o_next.tier = atlc_pkg::TIER_EW75;
                atlc_pkg::TIER_NS90: o_next.tier = atlc_pkg::TIER_NS75;
                atlc_pkg::TIER_EW75,
                atlc_pkg::TIER_NS75: o_next.tier = atlc_pkg::TIER_BASE;
                default: begin
                    // base stays
                end
            endcase
        end
    end

endmodule

// File: sv/atlc_core.sv
// Controller state and result register: one input word updated per cycle unless the result word is stalled.
// Depends on atlc_pkg and atlc_tier.
module atlc_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  atlc_pkg::t_cfg      i_cfg,
    input  logic                i_in_valid,
    input  atlc_pkg::t_in_word  i_in_data,
    output logic                o_in_ready,
    output logic                o_valid,
    output atlc_pkg::t_out_word o_data,
    input  logic                i_ready
);

    localparam int CB = atlc_pkg::CAR_COUNT_BITS;
    localparam int MB = atlc_pkg::MS_COUNT_BITS;
    localparam int LW = atlc_pkg::LOAD_W;

    // Controller state
    atlc_pkg::t_phase              r_phase, n_phase;
    atlc_pkg::t_tier_st            r_tier_st, n_tier_st;
    logic [MB-1:0]                 r_elapsed, n_elapsed;
    logic [atlc_pkg::SUBSEC_W-1:0] r_subsec, n_subsec;
    logic [atlc_pkg::SEC_W-1:0]    r_ew_sec, n_ew_sec;
    logic [atlc_pkg::SEC_W-1:0]    r_ns_sec, n_ns_sec;
    logic [CB-1:0]                 r_ew_count, n_ew_count;
    logic [CB-1:0]                 r_ns_count, n_ns_count;
    logic                          r_reload_pending;

    // Result register
    logic                          r_res_valid;
    atlc_pkg::t_out_word           r_res, n_res;

    logic                          take;
    logic [CB-1:0]                 ew_cnt_inc;
    logic [CB-1:0]                 ns_cnt_inc;
    logic [MB-1:0]                 elapsed_inc;
    logic [atlc_pkg::SUBSEC_W-1:0] subsec_inc;
    logic                          phase_end;
    atlc_pkg::t_tier_st            wrap_tier_st;
    atlc_pkg::t_phase              ld_phase;
    atlc_pkg::t_tier               ld_tier;
    logic [LW-1:0]                 y1, y2, y3, ge, gn;
    logic [LW-1:0]                 ew_ld_ms, ns_ld_ms;
    logic [atlc_pkg::SEC_W-1:0]    ew_ld, ns_ld;

    assign o_in_ready = !r_res_valid || i_ready;
    assign take       = i_in_valid && o_in_ready;

    // Count car pulses, saturating
    assign ew_cnt_inc = (i_in_data.ew_car && (r_ew_count != {CB{1'b1}})) ? r_ew_count + 1'b1
                                                                         : r_ew_count;
    assign ns_cnt_inc = (i_in_data.ns_car && (r_ns_count != {CB{1'b1}})) ? r_ns_count + 1'b1
                                                                         : r_ns_count;

    // Advance the millisecond counters on a tick
    assign elapsed_inc = (i_in_data.ms_tick && (r_elapsed != {MB{1'b1}})) ? r_elapsed + 1'b1
                                                                          : r_elapsed;
    assign subsec_inc  = (i_in_data.ms_tick && (r_subsec < atlc_pkg::MS_PER_SECOND))
                         ? r_subsec + 1'b1 : r_subsec;

    assign phase_end = elapsed_inc >=
                       MB'(atlc_pkg::phase_dur(r_phase, r_tier_st.tier, i_cfg));

    atlc_tier u_tier (
        .i_ew_count  (ew_cnt_inc),
        .i_ns_count  (ns_cnt_inc),
        .i_threshold (i_cfg.imbalance_threshold),
        .i_cur       (r_tier_st),
        .o_next      (wrap_tier_st)
    );

    // Phase, tier and counts after the end-of-phase test
    always_comb begin
        n_phase    = r_phase;
        n_tier_st  = r_tier_st;
        n_elapsed  = elapsed_inc;
        n_ew_count = ew_cnt_inc;
        n_ns_count = ns_cnt_inc;
        if (phase_end) begin
            n_elapsed = '0;
            n_phase   = atlc_pkg::next_phase(r_phase);
            if (r_phase == atlc_pkg::PH_NS_YELLOW) begin
                n_tier_st  = wrap_tier_st;
                n_ew_count = '0;
                n_ns_count = '0;
            end
        end
    end

    // Display reload values for the phase the item ends in
    assign ld_phase = n_phase;
    assign ld_tier  = n_tier_st.tier;
    assign y1 = LW'(i_cfg.yellow_red_ms);
    assign y2 = y1 << 1;
    assign y3 = y2 + y1;
    assign ge = LW'(atlc_pkg::green_ew(ld_tier, i_cfg));
    assign gn = LW'(atlc_pkg::green_ns(ld_tier, i_cfg));

    always_comb begin
        case (ld_phase)
            atlc_pkg::PH_RED1: begin
                ew_ld_ms = y1;
                ns_ld_ms = ge + y3;
            end
            atlc_pkg::PH_EW_GREEN: begin
                ew_ld_ms = ge;
                ns_ld_ms = ge + y2;
            end
            atlc_pkg::PH_EW_YELLOW: begin
                ew_ld_ms = y1;
                ns_ld_ms = y2;
            end
            atlc_pkg::PH_RED2: begin
                ew_ld_ms = gn + y3;
                ns_ld_ms = y1;
            end
            atlc_pkg::PH_NS_GREEN: begin
                ew_ld_ms = gn + y2;
                ns_ld_ms = gn;
            end
            default: begin
                ew_ld_ms = y2;
                ns_ld_ms = y1;
            end
        endcase
    end

    assign ew_ld = atlc_pkg::secs(ew_ld_ms);
    assign ns_ld = atlc_pkg::secs(ns_ld_ms);

    // Reload displays, then count them down on each full second
    always_comb begin
        n_ew_sec = r_ew_sec;
        n_ns_sec = r_ns_sec;
        n_subsec = subsec_inc;
        if (phase_end || r_reload_pending) begin
            n_ew_sec = ew_ld;
            n_ns_sec = ns_ld;
        end
        if (subsec_inc >= atlc_pkg::MS_PER_SECOND) begin
            n_subsec = '0;
            if (n_ew_sec != '0) n_ew_sec = n_ew_sec - 1'b1;
            if (n_ns_sec != '0) n_ns_sec = n_ns_sec - 1'b1;
        end
    end

    // Build the result word from the updated state
    always_comb begin
        n_res.ew_light        = 2'(atlc_pkg::ew_lamp(n_phase));
        n_res.ns_light        = 2'(atlc_pkg::ns_lamp(n_phase));
        n_res.phase_now       = 3'(n_phase);
        n_res.tier_now        = 3'(n_tier_st.tier);
        n_res.ew_seconds_left = n_ew_sec;
        n_res.ns_seconds_left = n_ns_sec;
        n_res.ew_cars_seen    = atlc_pkg::cars_seen(n_ew_count);
        n_res.ns_cars_seen    = atlc_pkg::cars_seen(n_ns_count);
    end

    // Commit state on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= atlc_pkg::PH_RED1;
            r_tier_st        <= '{tier: atlc_pkg::TIER_BASE, ew_streak: 2'd0, ns_streak: 2'd0};
            r_elapsed        <= '0;
            r_subsec         <= '0;
            r_ew_sec         <= '0;
            r_ns_sec         <= '0;
            r_ew_count       <= '0;
            r_ns_count       <= '0;
            r_reload_pending <= 1'b1;
        end else if (take) begin
            r_phase          <= n_phase;
            r_tier_st        <= n_tier_st;
            r_elapsed        <= n_elapsed;
            r_subsec         <= n_subsec;
            r_ew_sec         <= n_ew_sec;
            r_ns_sec         <= n_ns_sec;
            r_ew_count       <= n_ew_count;
            r_ns_count       <= n_ns_count;
            r_reload_pending <= 1'b0;
        end
    end

    // Result valid: fill on take, drain when the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_res_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_res_valid;
    assign o_data  = r_res;

endmodule

// File: sv/atlc_checker.sv
// Port-level checker for the traffic light controller, bound to the top level.
// Depends on atlc_pkg and adaptive_traffic_light_controller_assert.svh.
`include "adaptive_traffic_light_controller_assert.svh"

module atlc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input atlc_pkg::t_out_word i_out_data
);

    logic stalled;
    logic ew_green_ph;
    logic ns_green_ph;
    logic green_ph;
    logic lamps_ok;
    logic order_ok;

    // Decode the result word once for the checks below
    assign stalled     = i_out_valid && !i_out_ready;
    assign ew_green_ph = i_out_data.phase_now == atlc_pkg::PH_EW_GREEN;
    assign ns_green_ph = i_out_data.phase_now == atlc_pkg::PH_NS_GREEN;
    assign green_ph    = ew_green_ph || ns_green_ph;
    assign lamps_ok    = ((i_out_data.ew_light == atlc_pkg::LAMP_GREEN) == ew_green_ph)
                      && ((i_out_data.ns_light == atlc_pkg::LAMP_GREEN) == ns_green_ph);
    assign order_ok    = ew_green_ph
                       ? (i_out_data.ns_seconds_left >= i_out_data.ew_seconds_left)
                       : (i_out_data.ew_seconds_left >= i_out_data.ns_seconds_left);

    // Stalled result word holds
    `ATLC_CHECK_NEXT(a_stall_hold, stalled, i_out_valid && $stable(i_out_data), "held word changed")

    // Output stage empties on reset
    `ATLC_CHECK_RESET(a_reset_empty, !i_out_valid, "result valid after reset")

    // Lamps follow the reported phase
    `ATLC_CHECK_NOW(a_lamp_phase, i_out_valid, lamps_ok, "lamp does not match phase")

    // Cross traffic waits at least as long as the green side
    `ATLC_CHECK_NOW(a_green_order, i_out_valid && green_ph, order_ok, "red side below green side")

endmodule

bind adaptive_traffic_light_controller atlc_checker u_atlc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_valid),
    .i_out_ready (i_ready),
    .i_out_data  (o_data)
);
